// ===== rtl/core/sdw_pkg.sv =====
// shared types and constants of the signed decimal digit writer
package sdw_pkg;

    // width of one configuration register and of the result address and data fields
    localparam int REG_W = 8;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_ADDR_BASE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_CODE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DASH_CODE  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BLANK_CODE = 2'd3;

    // magnitude that passed the range check is below 10**8 < 2**27
    localparam int MAG_W = 27;

    // divide by ten through a reciprocal: q = (x * RECIP) >> SHIFT
    localparam logic [31:0] DIV10_RECIP = 32'hCCCC_CCCD;
    localparam int DIV10_SHIFT = 35;

    // decimal digit width
    localparam int DIGIT_W = 4;

    // quotient and remainder of one divide-by-ten step
    typedef struct packed {
        logic [MAG_W-1:0]   quot;
        logic [DIGIT_W-1:0] rem;
    } t_div10_res;

endpackage

// ===== rtl/core/sdw_div10.sv =====
// divide-by-ten unit: one decimal digit per use
module sdw_div10
    import sdw_pkg::*;
(
    input  logic [MAG_W-1:0] i_mag,
    output t_div10_res       o_res
);

    // wide enough that the quotient field sits inside the product
    localparam int PROD_W = DIV10_SHIFT + MAG_W;

    logic [PROD_W-1:0] prod;
    logic [MAG_W-1:0]  quot;
    logic [MAG_W-1:0]  times_ten;
    logic [MAG_W-1:0]  diff;

    // reciprocal multiply gives the exact quotient
    assign prod = PROD_W'(i_mag) * PROD_W'(DIV10_RECIP);
    assign quot = prod[DIV10_SHIFT +: MAG_W];

    // remainder as x - 10q, q*10 built from two shifts
    assign times_ten = (quot << 3) + (quot << 1);
    assign diff      = i_mag - times_ten;

    assign o_res.quot = quot;
    assign o_res.rem  = diff[DIGIT_W-1:0];

endmodule

// ===== rtl/core/signed_decimal_digit_writer_core.sv =====
// signed number to digit-register writes for a seven-segment display
//
//  channel  | handshake               | fields
//  ---------+-------------------------+----------------------------------------------
//  input    | start, busy             | i_value
//  result   | o_strobe                | o_reg_address, o_reg_data, o_last, o_overflow
//  config   | i_cfg_we                | i_cfg_index, i_cfg_data
//
// an item is taken when start is high and busy is low; busy then stays high
// through the range-check state and then one position per cycle in the emit state
// using the divide-by-ten unit, or through the range-check state alone when out of range
// digit results come on consecutive cycles, each registered out of an emit state;
// an error result is registered out of the range-check state
// the next item can be taken in the cycle the last result shows
// synchronous active-low reset clears the sequencer and loads register defaults
// the receiver cannot stall, so results go out without any hold
module signed_decimal_digit_writer_core
    import sdw_pkg::*;
#(
    parameter int NUM_DIGITS = 8
)
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic signed [31:0]   i_value,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [REG_W-1:0]     i_cfg_data,
    output logic                 o_strobe,
    output logic [REG_W-1:0]     o_reg_address,
    output logic [REG_W-1:0]     o_reg_data,
    output logic                 o_last,
    output logic                 o_overflow
);

    localparam int POS_W = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(NUM_DIGITS - 1);
    // largest magnitude that fits the positions, with room for the dash if negative
    localparam logic [31:0] POS_MAX = 32'(10 ** NUM_DIGITS - 1);
    localparam logic [31:0] NEG_MAX = 32'(10 ** (NUM_DIGITS - 1) - 1);

    // sequencer states
    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_CHECK = 2'd1;
    localparam logic [1:0] ST_EMIT  = 2'd2;

    logic [1:0]       r_state, n_state;
    logic [31:0]      r_mag, n_mag;
    logic             r_neg, n_neg;
    logic [POS_W-1:0] r_pos, n_pos;
    logic             r_dash_done, n_dash_done;

    logic [REG_W-1:0] r_addr_base;
    logic [REG_W-1:0] r_zero_code;
    logic [REG_W-1:0] r_dash_code;
    logic [REG_W-1:0] r_blank_code;

    logic             n_strobe;
    logic [REG_W-1:0] n_reg_address;
    logic [REG_W-1:0] n_reg_data;
    logic             n_last;
    logic             n_overflow;

    logic             accept;
    logic             too_big;
    logic [31:0]      value_bits;
    t_div10_res       div_res;

    assign accept     = start && !busy;
    assign busy       = (r_state != ST_IDLE);
    assign value_bits = i_value;
    assign too_big    = r_neg ? (r_mag > NEG_MAX) : (r_mag > POS_MAX);

    // shared divide-by-ten unit
    sdw_div10 u_div10 (
        .i_mag (r_mag[MAG_W-1:0]),
        .o_res (div_res)
    );

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr_base  <= REG_W'(1);
            r_zero_code  <= REG_W'(0);
            r_dash_code  <= REG_W'(10);
            r_blank_code <= REG_W'(15);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_ADDR_BASE:  r_addr_base  <= i_cfg_data;
                CFG_ZERO_CODE:  r_zero_code  <= i_cfg_data;
                CFG_DASH_CODE:  r_dash_code  <= i_cfg_data;
                CFG_BLANK_CODE: r_blank_code <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // sequencer next state and result
    always_comb begin
        n_state       = r_state;
        n_mag         = r_mag;
        n_neg         = r_neg;
        n_pos         = r_pos;
        n_dash_done   = r_dash_done;
        n_strobe      = 1'b0;
        n_reg_address = '0;
        n_reg_data    = '0;
        n_last        = 1'b0;
        n_overflow    = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_neg   = value_bits[31];
                    n_mag   = value_bits[31] ? (~value_bits + 32'd1) : value_bits;
                    n_state = ST_CHECK;
                end
            end
            ST_CHECK: begin
                n_pos       = '0;
                n_dash_done = 1'b0;
                if (too_big) begin
                    // single error result
                    n_strobe   = 1'b1;
                    n_last     = 1'b1;
                    n_overflow = 1'b1;
                    n_state    = ST_IDLE;
                end else begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                n_strobe      = 1'b1;
                n_reg_address = r_addr_base + REG_W'(r_pos);
                // digits while the magnitude is nonzero, then dash for a negative number, then blanks
                if (r_mag != 32'd0) begin
                    n_reg_data = r_zero_code + REG_W'(div_res.rem);
                    n_mag      = 32'(div_res.quot);
                end else if (r_neg && !r_dash_done) begin
                    n_reg_data  = r_dash_code;
                    n_dash_done = 1'b1;
                end else begin
                    n_reg_data = r_blank_code;
                end
                if (r_pos == POS_LAST) begin
                    n_last  = 1'b1;
                    n_state = ST_IDLE;
                end else begin
                    n_pos = r_pos + POS_W'(1);
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            o_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            o_strobe <= n_strobe;
        end
    end

    // working and result registers
    always_ff @(posedge i_clk) begin
        r_mag         <= n_mag;
        r_neg         <= n_neg;
        r_pos         <= n_pos;
        r_dash_done   <= n_dash_done;
        o_reg_address <= n_reg_address;
        o_reg_data    <= n_reg_data;
        o_last        <= n_last;
        o_overflow    <= n_overflow;
    end

endmodule

// ===== rtl/core/sdw_checker.sv =====
// port-level checks of the digit writer and their binding
module sdw_checker
    import sdw_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             start,
    input logic             busy,
    input logic             o_strobe,
    input logic [REG_W-1:0] o_reg_address,
    input logic [REG_W-1:0] o_reg_data,
    input logic             o_last,
    input logic             o_overflow
);

    // an error result is alone and carries zero fields
    a_ovf_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_overflow) |-> (o_last && o_reg_address == '0 && o_reg_data == '0))
        else $error("error result not final or fields not zero");

    // an accepted item makes the block busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not raise busy");

    // no result appears right after an idle cycle
    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy |=> !o_strobe)
        else $error("result out of an idle block");

    // digit writes of one item come on consecutive cycles
    a_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_last) |=> o_strobe)
        else $error("gap inside a result burst");

    // an unfinished burst keeps the block busy
    a_busy_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_last) |-> busy)
        else $error("block idle before last result");

endmodule

bind signed_decimal_digit_writer_core sdw_checker u_sdw_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .start         (start),
    .busy          (busy),
    .o_strobe      (o_strobe),
    .o_reg_address (o_reg_address),
    .o_reg_data    (o_reg_data),
    .o_last        (o_last),
    .o_overflow    (o_overflow)
);
